### sv/pmm_pkg.sv
// ----------------------------------------------------------------------------
// pmm_pkg: shared definitions for the packed int8/int4 systolic matmul
// Array size, field widths, register map, cell word type, the controller
// state type and the packed cell product.
// ----------------------------------------------------------------------------
package pmm_pkg;

	localparam int LANES    = 8;
	localparam int ACC_W    = 48;
	localparam int LEN_W    = 13;
	localparam int IDX_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [LEN_W-1:0] SUM_LENGTH_RESET = 13'd768;

	// Register select is the word address bit of paddr.
	localparam logic REG_SUM_LENGTH = 1'b0;

	// Word that travels along a row of cells together with the A byte.
	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic signed [BYTE_W-1:0] data;
	} a_flow_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_DRAIN
	} pmm_state_t;

	// Product of a signed byte with the packed B byte (signed high nibble at
	// bit 13, unsigned low nibble at bit 0). Bits 24:13 of the product land at
	// bit 24 of the result and bits 11:0 at bit 0; bit 12 is dropped.
	function automatic logic [ACC_W-1:0] cell_term(logic signed [BYTE_W-1:0] a,
		logic [BYTE_W-1:0] b);
		logic signed [16:0] pb;
		logic signed [24:0] p;
		pb = {b[7:4], 9'b0, b[3:0]};
		p  = a * pb;
		return {12'b0, p[24:13], 12'b0, p[11:0]};
	endfunction

endpackage

### sv/pmm_cell.sv
// ----------------------------------------------------------------------------
// pmm_cell: one processing cell of the output-stationary array
// Accumulates the packed product of the A word from the left and the B byte
// from above, passes both on, and parks its tile sum in a shift chain.
// ----------------------------------------------------------------------------
module pmm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pmm_pkg::a_flow_t          a_in,
	input  logic [pmm_pkg::BYTE_W-1:0] b_in,
	output pmm_pkg::a_flow_t          a_out,
	output logic [pmm_pkg::BYTE_W-1:0] b_out,
	input  logic                      shift_en,
	input  logic [pmm_pkg::ACC_W-1:0] shift_in,
	output logic [pmm_pkg::ACC_W-1:0] res
);
	import pmm_pkg::*;

	a_flow_t            a_q;
	logic [BYTE_W-1:0]  b_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   res_q;
	logic [ACC_W-1:0]   acc_sum;

	assign acc_sum = acc_q + cell_term(a_in.data, b_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			acc_q <= '0;
		end else begin
			a_q <= a_in;
			if (a_in.valid) begin
				// The closing word of a tile starts the next tile from zero.
				acc_q <= a_in.last ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		b_q <= b_in;
		if (a_in.valid && a_in.last) begin
			res_q <= acc_sum;
		end else if (shift_en) begin
			res_q <= shift_in;
		end
	end

	assign a_out = a_q;
	assign b_out = b_q;
	assign res   = res_q;

endmodule

### sv/packed_int8_int4_systolic_matmul.sv
// ----------------------------------------------------------------------------
// packed_int8_int4_systolic_matmul: LANES x LANES output-stationary array
// Each input word carries one column of A and one row of B; after a tile of
// sum_length words the block emits every cell's 48-bit sum.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (item_valid / item_stall, a_bytes, b_bytes) takes one word
// per cycle while a tile is being summed. A words walk right along the rows and
// B bytes walk down the columns, skewed so that the A and B bytes of one word
// meet in each cell. The word that completes a tile raises item_stall until
// the tile is out: that word first travels to the far corner cell, then
// LANES*LANES result words follow, one per cycle unless result_stall holds
// them, column outer and row inner, with last_of_tile on the final one.
// The output channel (result_valid / result_stall) has its own register;
// while result_stall is high the drain simply pauses and nothing is lost.
// sum_length (APB, address 0) defaults to 768 after reset; a value of 0
// closes a tile on every word. Reset clears all sums and the word count;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module packed_int8_int4_systolic_matmul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pmm_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [pmm_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [pmm_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [63:0]                      a_bytes,
	input  logic [63:0]                      b_bytes,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [pmm_pkg::ACC_W-1:0] sum_value,
	output logic [pmm_pkg::IDX_W-1:0]        row_index,
	output logic [pmm_pkg::IDX_W-1:0]        column_index,
	output logic                             last_of_tile
);
	import pmm_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANES - 1);

	pmm_state_t        state_q;
	pmm_state_t        state_d;
	logic [LEN_W-1:0]  sum_length_q;
	logic [LEN_W-1:0]  step_q;
	logic [LEN_W-1:0]  taken;
	logic              tile_end;
	logic              item_acc;
	logic              corner_done;
	logic              shift_go;
	logic              drain_last;
	logic [IDX_W-1:0]  drain_row_q;
	logic [IDX_W-1:0]  drain_col_q;
	logic              result_valid_q;
	logic [ACC_W-1:0]  sum_value_q;
	logic [IDX_W-1:0]  row_index_q;
	logic [IDX_W-1:0]  column_index_q;
	logic              last_of_tile_q;

	a_flow_t           a_grid [LANES][LANES+1];
	logic [BYTE_W-1:0] b_grid [LANES+1][LANES];
	logic [ACC_W-1:0]  res_grid [LANES][LANES];

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SUM_LENGTH) ? CFG_DATA_W'(sum_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_length_q <= SUM_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SUM_LENGTH) begin
			sum_length_q <= pwdata[LEN_W-1:0];
		end
	end

	// Word count within the tile.
	assign item_acc = item_valid && !item_stall;
	assign taken    = LEN_W'(step_q + 1'b1);
	assign tile_end = (taken >= sum_length_q) || (taken == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (item_acc) begin
			step_q <= tile_end ? '0 : taken;
		end
	end

	// Skew lines: row m delays its A byte after acceptance through a shift chain
	// whose length grows with m, and column n its B byte likewise with n.
	for (genvar m = 0; m < LANES; m++) begin : g_row
		a_flow_t skew_q [m+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int k = 0; k <= m; k++) begin
					skew_q[k] <= '0;
				end
			end else begin
				skew_q[0].valid <= item_acc;
				skew_q[0].last  <= item_acc && tile_end;
				skew_q[0].data  <= a_bytes[BYTE_W*m +: BYTE_W];
				for (int k = 1; k <= m; k++) begin
					skew_q[k] <= skew_q[k-1];
				end
			end
		end

		assign a_grid[m][0] = skew_q[m];
	end

	for (genvar n = 0; n < LANES; n++) begin : g_col
		logic [BYTE_W-1:0] skew_q [n+1];

		always_ff @(posedge clk) begin
			skew_q[0] <= b_bytes[BYTE_W*n +: BYTE_W];
			for (int k = 1; k <= n; k++) begin
				skew_q[k] <= skew_q[k-1];
			end
		end

		assign b_grid[0][n] = skew_q[n];
	end

	// Cell grid. The drain chain runs in emission order, row inner, so each
	// cell loads from the next row, and the bottom of a column from the top of
	// the next column.
	for (genvar m = 0; m < LANES; m++) begin : g_m
		for (genvar n = 0; n < LANES; n++) begin : g_n
			logic [ACC_W-1:0] chain_in;

			if (m < LANES - 1) begin : g_down
				assign chain_in = res_grid[m+1][n];
			end else if (n < LANES - 1) begin : g_wrap
				assign chain_in = res_grid[0][n+1];
			end else begin : g_end
				assign chain_in = '0;
			end

			pmm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.a_in     (a_grid[m][n]),
				.b_in     (b_grid[m][n]),
				.a_out    (a_grid[m][n+1]),
				.b_out    (b_grid[m+1][n]),
				.shift_en (shift_go),
				.shift_in (chain_in),
				.res      (res_grid[m][n])
			);
		end
	end

	// The closing word has left the far corner: every cell holds its sum.
	assign corner_done = a_grid[LANES-1][LANES].valid && a_grid[LANES-1][LANES].last;

	assign shift_go   = (state_q == ST_DRAIN) && (!result_valid_q || !result_stall);
	assign drain_last = (drain_row_q == LAST_IDX) && (drain_col_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		unique case (state_q)
			ST_RUN: begin
				item_stall = 1'b0;
				if (item_acc && tile_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (corner_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (shift_go && drain_last) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_row_q <= '0;
			drain_col_q <= '0;
		end else if (shift_go) begin
			if (drain_row_q == LAST_IDX) begin
				drain_row_q <= '0;
				drain_col_q <= drain_last ? '0 : drain_col_q + 1'b1;
			end else begin
				drain_row_q <= drain_row_q + 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (shift_go) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_go) begin
			sum_value_q    <= res_grid[0][0];
			row_index_q    <= drain_row_q;
			column_index_q <= drain_col_q;
			last_of_tile_q <= drain_last;
		end
	end

	assign result_valid = result_valid_q;
	assign sum_value    = sum_value_q;
	assign row_index    = row_index_q;
	assign column_index = column_index_q;
	assign last_of_tile = last_of_tile_q;

	a_tile_close: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && tile_end |=> item_stall)
		else $error("input not held off after the closing word of a tile");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RUN |-> step_q == '0)
		else $error("word count not cleared while a tile drains");

	a_corner_flush: assert property (@(posedge clk) disable iff (!arst_n)
		corner_done |-> state_q == ST_FLUSH)
		else $error("closing word reached the corner outside the flush");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_tile |-> row_index == LAST_IDX && column_index == LAST_IDX)
		else $error("last_of_tile on a word other than the final cell");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH && corner_done |=> drain_row_q == '0 && drain_col_q == '0)
		else $error("drain counters not at the first cell when the drain starts");

endmodule

### tb/sv/tb_packed_int8_int4_systolic_matmul.sv
// ----------------------------------------------------------------------------
// tb_packed_int8_int4_systolic_matmul: self-checking bench for the packed matmul
// A queue of A/B words feeds a clocked driver, and a clocked monitor compares
// every emitted cell sum with a cycle-free predictor of the array. Tile length
// is changed over APB between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_packed_int8_int4_systolic_matmul;

	import pmm_pkg::*;

	localparam logic [CFG_ADDR_W-1:0] SUM_LENGTH_ADDR = 3'd0;
	localparam int MAX_WAIT      = 17;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int MAX_REPORTS   = 30;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
	} word_pair_t;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} cell_sum_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [63:0]           a_bytes = '0;
	logic [63:0]           b_bytes = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b1;
	logic signed [ACC_W-1:0] sum_value;
	logic [IDX_W-1:0]      row_index;
	logic [IDX_W-1:0]      column_index;
	logic                  last_of_tile;

	// Predictor state: one wrapped sum per cell, the word count and the length.
	logic [ACC_W-1:0] cell_sums [LANES*LANES];
	logic [LEN_W-1:0] step_count = '0;
	logic [LEN_W-1:0] tile_len = SUM_LENGTH_RESET;

	word_pair_t words_pending [$];
	cell_sum_t  sums_due [$];

	bit item_fired;
	bit result_fired;
	bit tx_steady;
	bit rx_steady;
	bit hold_request;
	int tx_gap_left;
	int rx_wait_left;
	int hold_left;
	int idle_cycles;
	int failures;
	int words_taken;
	int sums_checked;
	int tiles_due;
	int cfg_writes;
	cell_sum_t due;

	packed_int8_int4_systolic_matmul u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.a_bytes      (a_bytes),
		.b_bytes      (b_bytes),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sum_value    (sum_value),
		.row_index    (row_index),
		.column_index (column_index),
		.last_of_tile (last_of_tile)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Contribution of one cell: the 25-bit product is split into two 12-bit
	// fields and bit 12 is thrown away.
	function automatic logic [ACC_W-1:0] packed_term(logic signed [7:0] a, logic [7:0] b);
		int          av;
		int          hi;
		int          lo;
		int          p;
		logic [24:0] pu;
		av = a;
		hi = $signed(b[7:4]);
		lo = b[3:0];
		p  = av * (hi * 8192 + lo);
		pu = p[24:0];
		return {12'b0, pu[24:13], 12'b0, pu[11:0]};
	endfunction

	function automatic void accumulate_word(logic [63:0] a_w, logic [63:0] b_w);
		logic [LEN_W-1:0] taken;
		cell_sum_t        s;
		for (int m = 0; m < LANES; m++)
			for (int n = 0; n < LANES; n++)
				cell_sums[m*LANES+n] += packed_term(a_w[8*m +: 8], b_w[8*n +: 8]);
		taken = step_count + 1'b1;
		if (taken >= tile_len || taken == '0) begin
			for (int n = 0; n < LANES; n++) begin
				for (int m = 0; m < LANES; m++) begin
					s.sum  = cell_sums[m*LANES+n];
					s.row  = IDX_W'(m);
					s.col  = IDX_W'(n);
					s.last = (m == LANES-1) && (n == LANES-1);
					sums_due.push_back(s);
				end
			end
			foreach (cell_sums[k])
				cell_sums[k] = '0;
			step_count = '0;
			tiles_due++;
		end else begin
			step_count = taken;
		end
	endfunction

	function automatic logic [63:0] rand_lanes();
		logic [63:0] w;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 3))
				0: w[8*i +: 8] = 8'h80;
				1: w[8*i +: 8] = ($urandom_range(0, 1) != 0) ? 8'h7F : 8'hFF;
				default: w[8*i +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return w;
	endfunction

	function automatic int draw_wait(bit steady);
		return steady ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void report_miss(string field, logic [ACC_W-1:0] want,
		logic [ACC_W-1:0] got);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endfunction

	// Input side: a word is taken at the rising edge; the driver moves at the
	// falling edge.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			accumulate_word(a_bytes, b_bytes);
			words_taken++;
			item_fired = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (item_fired || !item_valid)) begin
			item_fired = 1'b0;
			if (tx_gap_left > 0) begin
				tx_gap_left--;
				item_valid <= 1'b0;
			end else if (words_pending.size() != 0) begin
				word_pair_t w;
				w = words_pending.pop_front();
				item_valid  <= 1'b1;
				a_bytes     <= w.a;
				b_bytes     <= w.b;
				tx_gap_left = draw_wait(tx_steady);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Output side: the receiver stalls between words, and once per run holds
	// off for a long stretch so the array backs up into its input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_fired) begin
				result_fired = 1'b0;
				rx_wait_left = draw_wait(rx_steady);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				result_stall <= 1'b1;
			end else if (rx_wait_left > 0) begin
				rx_wait_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			result_fired = 1'b1;
			sums_checked++;
			if (sums_due.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: unexpected sum word, expected none, actual %h row %0d col %0d",
						$time, sum_value, row_index, column_index);
			end else begin
				due = sums_due.pop_front();
				if (sum_value !== due.sum)
					report_miss("sum_value", due.sum, sum_value);
				if (row_index !== due.row)
					report_miss("row_index", ACC_W'(due.row), ACC_W'(row_index));
				if (column_index !== due.col)
					report_miss("column_index", ACC_W'(due.col), ACC_W'(column_index));
				if (last_of_tile !== due.last)
					report_miss("last_of_tile", ACC_W'(due.last), ACC_W'(last_of_tile));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired with %0d sums outstanding", $time, sums_due.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_write(input logic [LEN_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = SUM_LENGTH_ADDR;
		pwdata  = {{(CFG_DATA_W-LEN_W){1'b0}}, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tile_len = value;
		cfg_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apb_read_check();
		logic [CFG_DATA_W-1:0] want;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = SUM_LENGTH_ADDR;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		want = {{(CFG_DATA_W-LEN_W){1'b0}}, tile_len};
		if (prdata !== want)
			report_miss("sum_length readback", ACC_W'(want), ACC_W'(prdata));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Blocks until the array has nothing queued, in flight or owed.
	task automatic settle();
		while (words_pending.size() != 0 || item_valid || sums_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_word(input logic [63:0] a, input logic [63:0] b);
		word_pair_t w;
		w.a = a;
		w.b = b;
		words_pending.push_back(w);
	endtask

	initial begin
		int n_words;
		foreach (cell_sums[k])
			cell_sums[k] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset length first, so these words only partly fill a tile.
		apb_read_check();
		push_word(64'h0, 64'h0);
		push_word(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		push_word(64'h8080_8080_8080_8080, 64'h8888_8888_8888_8888);
		settle();

		// Shortest tile: closes the partial tile above, then one word per tile.
		apb_write(13'd1);
		apb_read_check();
		push_word(64'h7F7F_7F7F_7F7F_7F7F, 64'h7777_7777_7777_7777);
		push_word(64'h807F_00FF_807F_01FF, 64'h8778_F00F_807F_FF08);
		push_word(64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F);
		push_word(64'h0123_4567_89AB_CDEF, 64'hF0F0_0F0F_8F8F_7070);
		settle();

		// A length of zero behaves like one.
		apb_write(13'd0);
		push_word(64'hFF80_7F01_FE02_FD03, 64'h0F1E_2D3C_4B5A_6978);
		push_word(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080);
		settle();

		// Long lengths, then a cut mid-tile that closes on the next word.
		apb_write(13'd4096);
		repeat (4) push_word(rand_lanes(), rand_lanes());
		settle();
		apb_write(13'd8191);
		apb_read_check();
		repeat (3) push_word(rand_lanes(), rand_lanes());
		settle();
		apb_write(13'd2);
		push_word(64'h7F80_7F80_7F80_7F80, 64'h08F7_08F7_08F7_08F7);
		settle();

		// Receiver hold-off while the sender keeps offering back to back.
		tx_steady = 1'b1;
		apb_write(13'd1);
		hold_request = 1'b1;
		repeat (10) push_word(rand_lanes(), rand_lanes());
		settle();

		// Random phases with varied lengths and idling patterns.
		for (int ph = 0; ph < 9; ph++) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			case (ph % 3)
				0: apb_write(LEN_W'($urandom_range(0, 4)));
				1: apb_write(LEN_W'($urandom_range(5, 16)));
				default: apb_write(LEN_W'($urandom_range(1, 40)));
			endcase
			if ($urandom_range(0, 1) != 0)
				apb_read_check();
			n_words = $urandom_range(16, 28);
			repeat (n_words) push_word(rand_lanes(), rand_lanes());
			settle();
		end

		failures += sums_due.size();
		$display("covered %0d words, %0d tiles, %0d sum words checked, %0d length writes",
			words_taken, tiles_due, sums_checked, cfg_writes);
		$display("lengths 0 to 8191 incl. mid-tile cuts, a long output hold-off and random idling");
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
